// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: design/mcom_pkg.sv
// Shared constants, types and command/status structs for the center-of-mass block.
package mcom_pkg;
    localparam int COORD_BITS = 12;
    localparam int MAX_FACES  = 1024;
    localparam int VOL_BITS   = 48;
    localparam int MOM_BITS   = 62;
    localparam int CNT_BITS   = 11;
    localparam int DEN_BITS   = VOL_BITS + 2;
    localparam int QCNT_BITS  = 6;
    localparam int IN_BYTES   = 14;
    localparam int OUT_BYTES  = 5;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL1  = 7'b0000010,
        ST_MUL2  = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_PREP  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic mul1;      // cross products
        logic mul2;      // determinant and vertex sums
        logic acc;       // accumulate
        logic div_start; // set up division
        logic div_step;  // one quotient bit, all axes
        logic clear;     // clear sums after result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;
        logic div_done;
    } dp_stat_t;
endpackage

// File: design/mcom_ctrl.sv
// Controller state machine for the center-of-mass block.
module mcom_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_taken,
    input  mcom_pkg::dp_stat_t stat,
    output mcom_pkg::dp_cmd_t  cmd,
    output logic              in_ready,
    output logic              out_valid
);
    import mcom_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
                if (in_fire)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1 = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2 = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (stat.last)
                begin
                    state_next = ST_PREP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREP:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_taken)
                begin
                    cmd.clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// File: design/mcom_dp.sv
// Datapath: determinant, accumulators and a restoring divider for the centers.
module mcom_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcom_pkg::dp_cmd_t             cmd,
    input  logic [mcom_pkg::IN_BYTES*8-1:0] in_data,
    input  logic                          in_last,
    output mcom_pkg::dp_stat_t            stat,
    output logic [mcom_pkg::OUT_BYTES*8-1:0] out_data
);
    import mcom_pkg::*;

    localparam int PBITS = 2*COORD_BITS + 1;   // cross product
    localparam int DBITS = 3*COORD_BITS + 4;   // determinant
    localparam int SBITS = COORD_BITS + 2;     // vertex sum
    localparam int UBITS = MOM_BITS;           // magnitude width
    localparam int QBITS = MOM_BITS;

    coord_t v_reg [9];
    logic   last_reg;
    logic signed [PBITS-1:0] cr_reg [3];
    logic signed [DBITS-1:0] det_reg;
    logic signed [SBITS-1:0] sum_reg [3];

    logic signed [VOL_BITS-1:0] vol_reg;
    logic signed [MOM_BITS-1:0] mom_reg [3];
    logic [CNT_BITS-1:0] cnt_reg;
    logic                ovf_reg;

    logic [UBITS-1:0] rem_reg [3];
    logic [QBITS-1:0] num_reg [3];
    logic [DEN_BITS-1:0] den_reg;
    logic [2:0]       neg_reg;
    logic             zero_reg;
    logic [QCNT_BITS-1:0] step_reg;

    logic signed [COORD_BITS-1:0] ctr [3];
    logic full;

    assign full = (cnt_reg >= CNT_BITS'(MAX_FACES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                mom_reg[i] <= '0;
            end
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (cmd.acc)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    vol_reg <= vol_reg + VOL_BITS'(det_reg);
                    for (int i = 0; i < 3; i++)
                    begin
                        mom_reg[i] <= mom_reg[i] + MOM_BITS'(det_reg * sum_reg[i]);
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.clear)
            begin
                vol_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    mom_reg[i] <= '0;
                end
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (cmd.div_start)
            begin
                step_reg <= QCNT_BITS'(QBITS);
            end
            else if (cmd.div_step && step_reg != '0)
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    logic [UBITS:0] trial [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            trial[i] = {rem_reg[i], num_reg[i][QBITS-1]} - (UBITS+1)'(den_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 9; i++)
            begin
                v_reg[i] <= in_data[i*COORD_BITS +: COORD_BITS];
            end
            last_reg <= in_last;
        end
        if (cmd.mul1)
        begin
            cr_reg[0] <= PBITS'(v_reg[4]*v_reg[8]) - PBITS'(v_reg[5]*v_reg[7]);
            cr_reg[1] <= PBITS'(v_reg[3]*v_reg[8]) - PBITS'(v_reg[5]*v_reg[6]);
            cr_reg[2] <= PBITS'(v_reg[3]*v_reg[7]) - PBITS'(v_reg[4]*v_reg[6]);
        end
        if (cmd.mul2)
        begin
            det_reg <= DBITS'(v_reg[0]*cr_reg[0]) - DBITS'(v_reg[1]*cr_reg[1])
                     + DBITS'(v_reg[2]*cr_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= SBITS'(v_reg[i]) + SBITS'(v_reg[3+i]) + SBITS'(v_reg[6+i]);
            end
        end
        // Sums already hold the last face here.
        if (cmd.div_start)
        begin
            den_reg  <= vol_reg[VOL_BITS-1] ? DEN_BITS'(-{vol_reg, 2'b00})
                                            : DEN_BITS'({vol_reg, 2'b00});
            zero_reg <= (vol_reg == '0);
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= mom_reg[i][MOM_BITS-1] ? -mom_reg[i] : mom_reg[i];
                rem_reg[i] <= '0;
                neg_reg[i] <= mom_reg[i][MOM_BITS-1] ^ vol_reg[VOL_BITS-1];
            end
        end
        else if (cmd.div_step && step_reg != '0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (!trial[i][UBITS])
                begin
                    rem_reg[i] <= trial[i][UBITS-1:0];
                    num_reg[i] <= {num_reg[i][QBITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= {rem_reg[i][UBITS-2:0], num_reg[i][QBITS-1]};
                    num_reg[i] <= {num_reg[i][QBITS-2:0], 1'b0};
                end
            end
        end
    end

    // Saturate magnitude quotient and apply sign.
    localparam logic [QBITS-1:0] MAXP = QBITS'((1 << (COORD_BITS-1)) - 1);
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg)
            begin
                ctr[i] = '0;
            end
            else if (neg_reg[i])
            begin
                if (num_reg[i] > MAXP)
                begin
                    ctr[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
                end
                else
                begin
                    ctr[i] = -COORD_BITS'(num_reg[i]);
                end
            end
            else
            begin
                ctr[i] = (num_reg[i] > MAXP) ? COORD_BITS'(MAXP) : COORD_BITS'(num_reg[i]);
            end
        end
    end

    assign stat.last = last_reg;
    assign stat.div_done = (step_reg == QCNT_BITS'(1));
    assign out_data = (OUT_BYTES*8)'({ovf_reg, zero_reg, ctr[2], ctr[1], ctr[0]});
endmodule

// File: design/mesh_center_of_mass_core.sv
// Top level of the mesh center-of-mass block.
// Usage:
//   s_axis carries one triangle face per item: nine signed 12-bit coordinates
//   in tdata (a_x lowest ... c_z highest), last_face in tlast.
//   m_axis carries one result item per mesh, only after the face flagged last:
//   center_x, center_y, center_z, zero_volume, too_many_faces in tdata.
// Sequence:
//   An ordinary face passes through capture, cross products, determinant
//   and accumulate; the next face may enter once it has been accumulated.
//   The last face then adds a divider setup step and a bit-serial restoring
//   divide, one divider per axis with a shared divisor: m_axis_tvalid rises
//   once the divide is done, and the next face can enter only after the
//   result has been taken.
// Reset clears all sums, the face count and the overflow flag; no item is
// pending afterward.
// When the receiver stalls the result waits in its register, s_axis_tready
// stays low, and the sums clear only once the result is taken.
`include "assert_macros.svh"
module mesh_center_of_mass_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z, 4'b0
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata   // center_x,center_y,center_z,zero_volume,
                                        // too_many_faces, 2'b0
);
    import mcom_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_fire;
    logic     out_taken;

    assign in_fire   = s_axis_tvalid & s_axis_tready;
    assign out_taken = m_axis_tvalid & m_axis_tready;

    mcom_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_taken (out_taken),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    mcom_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .stat     (stat),
        .out_data (m_axis_tdata)
    );

    `ASSERT_NEVER(a_no_overlap, clk, rst_n, s_axis_tready && m_axis_tvalid, "in/out overlap")
    `ASSERT_CLK(a_clear_after, clk, rst_n, out_taken |=> s_axis_tready, "not idle after result")
    `ASSERT_NEVER(a_cmd_excl, clk, rst_n, cmd.load && cmd.div_step, "load during divide")
endmodule
